// File: src/srd_pkg.sv
// Shared types, codes and constants for the 6rd tunnel header filter.
package srd_pkg;

  localparam int unsigned MaxFrameBytes = 2048;
  localparam int unsigned TunHdrBytes   = 4;
  localparam int unsigned V4HdrBytes    = 20;
  localparam int unsigned V6HdrBytes    = 40;

  localparam logic [31:0] V4MaskMcast   = 32'hf000_0000;
  localparam logic [31:0] V4Mcast       = 32'he000_0000;
  localparam logic [31:0] V4MaskA       = 32'hff00_0000;
  localparam logic [31:0] V4Net10       = 32'h0a00_0000;
  localparam logic [31:0] V4MaskB       = 32'hfff0_0000;
  localparam logic [31:0] V4Net172      = 32'hac10_0000;
  localparam logic [31:0] V4MaskC       = 32'hffff_0000;
  localparam logic [31:0] V4Net192      = 32'hc0a8_0000;
  localparam logic [31:0] V4LinkLocal   = 32'ha9fe_0000;
  localparam logic [31:0] V4Bcast       = 32'hffff_ffff;
  localparam logic [7:0]  V4Zero        = 8'h00;
  localparam logic [7:0]  V4Loop        = 8'h7f;

  localparam logic [7:0]  V6Mcast       = 8'hff;
  localparam logic [7:0]  V6LinkSite    = 8'hfe;
  localparam logic [7:0]  V6ScopeMask   = 8'h0f;
  localparam logic [7:0]  V6ScopeGlobal = 8'h0e;
  localparam logic [7:0]  V6LlMask      = 8'hc0;
  localparam logic [7:0]  V6LinkLocal   = 8'h80;
  localparam logic [7:0]  V6SiteLocal   = 8'hc0;

  localparam logic [2:0]  PrefixBytesReset = 3'd4;
  localparam logic [31:0] FamilyIpv6Reset  = 32'd24;

  typedef enum logic [0:0] {
    OP_EGRESS  = 1'b0,
    OP_INGRESS = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    CFG_PREFIX_BITS  = 3'd0,
    CFG_PREFIX_BYTES = 3'd1,
    CFG_MY_V4        = 3'd2,
    CFG_RELAY_V4     = 3'd3,
    CFG_FAMILY_IPV6  = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    RSN_OK             = 5'd0,
    RSN_TOO_BIG        = 5'd1,
    RSN_EG_NO_FAMILY   = 5'd2,
    RSN_EG_BAD_FAMILY  = 5'd3,
    RSN_EG_NO_V6       = 5'd4,
    RSN_EG_SRC_NOT_ME  = 5'd5,
    RSN_EG_BAD_V4_DST  = 5'd6,
    RSN_EG_BAD_V6_DST  = 5'd7,
    RSN_IN_NO_V4       = 5'd8,
    RSN_IN_IHL_SHORT   = 5'd9,
    RSN_IN_IHL_LONG    = 5'd10,
    RSN_IN_NO_V6       = 5'd11,
    RSN_IN_V4_MISMATCH = 5'd12,
    RSN_IN_BAD_V4_SRC  = 5'd13,
    RSN_IN_NOT_RELAY   = 5'd14,
    RSN_IN_BAD_V6_SRC  = 5'd15,
    RSN_IN_DST_NOT_ME  = 5'd16
  } reason_e;

  typedef struct packed {
    logic        opcode;
    logic [11:0] frame_length;
    logic [31:0] tun_family_word;
    logic [3:0]  ihl_words;
    logic [31:0] outer_v4_source;
    logic [63:0] inner_v6_source_high;
    logic [63:0] inner_v6_dest_high;
  } in_item_t;

  typedef struct packed {
    logic        forward;
    logic [4:0]  reason;
    logic [31:0] next_hop_v4;
    logic [5:0]  out_offset;
    logic [10:0] out_length;
  } out_item_t;

  typedef struct packed {
    logic [31:0] prefix_bits;
    logic [2:0]  prefix_bytes;
    logic [31:0] local_v4;
    logic [31:0] relay_v4;
    logic [31:0] tun_family_ipv6;
  } cfg_t;

endpackage

// File: src/sixrd_tunnel_header_filter_top.sv
// Top level of the 6rd tunnel header filter: input register, checks, result register.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  in_data_i   (srd_pkg::in_item_t)
//   out      output     out_valid_o/out_ready_i out_data_o (srd_pkg::out_item_t)
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A result passes the input register and then the result register before it is valid; one
// header per cycle sustained while out_ready_i stays high, set by the single check stage.
// Reset clears both valid flags and loads the register reset values.
// A stalled result holds the result register; the input register still takes one
// more transaction, and in_ready_o drops only when both registers are full.
module sixrd_tunnel_header_filter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  srd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output srd_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);

  srd_pkg::cfg_t      cfg;
  srd_pkg::in_item_t  s1_data_q;
  srd_pkg::out_item_t res;
  srd_pkg::out_item_t out_data_q;
  logic               s1_valid_q;
  logic               s1_valid_d;
  logic               out_valid_q;
  logic               out_valid_d;
  logic               in_take;
  logic               s2_adv;

  srd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  srd_check u_check (
    .item_i (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign s2_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_adv;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s2_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
    if (s2_adv) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_take_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted transaction did not reach the input register");

  a_adv_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_adv |=> out_valid_o)
    else $error("checked transaction did not reach the result register");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled while a register was free");

  a_forward_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.forward == (out_data_o.reason == srd_pkg::RSN_OK)))
    else $error("verdict and reason disagree");

  a_drop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.forward) |->
      (out_data_o.next_hop_v4 == 32'd0 && out_data_o.out_length == 11'd0))
    else $error("dropped transaction carries nonzero fields");

endmodule

// File: src/srd_check.sv
// Combinational header checks: verdict, reason, next hop, offset and length.
module srd_check (
  input  srd_pkg::in_item_t  item_i,
  input  srd_pkg::cfg_t      cfg_i,
  output srd_pkg::out_item_t res_o
);

  function automatic logic bad_v4(input logic [31:0] a);
    logic r;
    r = (a[31:24] == srd_pkg::V4Zero) || (a[31:24] == srd_pkg::V4Loop) ||
        ((a & srd_pkg::V4MaskMcast) == srd_pkg::V4Mcast) ||
        ((a & srd_pkg::V4MaskA) == srd_pkg::V4Net10) ||
        ((a & srd_pkg::V4MaskB) == srd_pkg::V4Net172) ||
        ((a & srd_pkg::V4MaskC) == srd_pkg::V4Net192) ||
        ((a & srd_pkg::V4MaskC) == srd_pkg::V4LinkLocal) ||
        (a == srd_pkg::V4Bcast);
    return r;
  endfunction

  function automatic logic bad_v6(input logic [63:0] hi);
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = hi[63:56];
    b1 = hi[55:48];
    return (b0 == 8'h00) ||
           ((b0 == srd_pkg::V6Mcast) &&
            ((b1 & srd_pkg::V6ScopeMask) != srd_pkg::V6ScopeGlobal)) ||
           ((b0 == srd_pkg::V6LinkSite) &&
            ((b1 & srd_pkg::V6LlMask) == srd_pkg::V6LinkLocal)) ||
           ((b0 == srd_pkg::V6LinkSite) &&
            ((b1 & srd_pkg::V6LlMask) == srd_pkg::V6SiteLocal));
  endfunction

  logic [31:0] pfx_mask;
  logic [31:0] src_emb;
  logic [31:0] dst_emb;
  logic        src_in_pfx;
  logic        dst_in_pfx;
  logic [11:0] len;
  logic [5:0]  skip;
  logic [11:0] skip_ext;
  srd_pkg::reason_e reason;
  logic [31:0] hop;

  assign len      = item_i.frame_length;
  assign skip     = {item_i.ihl_words, 2'b00};
  assign skip_ext = {6'd0, skip};

  // Clamp prefix length to two..four bytes and pick the embedded address window.
  always_comb begin
    unique case (cfg_i.prefix_bytes) inside
      3'd0, 3'd1, 3'd2: begin
        pfx_mask = 32'hffff_0000;
        src_emb  = item_i.inner_v6_source_high[47:16];
        dst_emb  = item_i.inner_v6_dest_high[47:16];
      end
      3'd3: begin
        pfx_mask = 32'hffff_ff00;
        src_emb  = item_i.inner_v6_source_high[39:8];
        dst_emb  = item_i.inner_v6_dest_high[39:8];
      end
      default: begin
        pfx_mask = 32'hffff_ffff;
        src_emb  = item_i.inner_v6_source_high[31:0];
        dst_emb  = item_i.inner_v6_dest_high[31:0];
      end
    endcase
  end

  assign src_in_pfx = (item_i.inner_v6_source_high[63:32] & pfx_mask) ==
                      (cfg_i.prefix_bits & pfx_mask);
  assign dst_in_pfx = (item_i.inner_v6_dest_high[63:32] & pfx_mask) ==
                      (cfg_i.prefix_bits & pfx_mask);

  always_comb begin
    hop = 32'd0;
    if (len >= 12'(srd_pkg::MaxFrameBytes)) begin
      reason = srd_pkg::RSN_TOO_BIG;
    end else if (item_i.opcode == srd_pkg::OP_EGRESS) begin
      if (len < 12'(srd_pkg::TunHdrBytes)) begin
        reason = srd_pkg::RSN_EG_NO_FAMILY;
      end else if (item_i.tun_family_word != cfg_i.tun_family_ipv6) begin
        reason = srd_pkg::RSN_EG_BAD_FAMILY;
      end else if (len < 12'(srd_pkg::TunHdrBytes + srd_pkg::V6HdrBytes)) begin
        reason = srd_pkg::RSN_EG_NO_V6;
      end else if (!src_in_pfx || (src_emb != cfg_i.local_v4)) begin
        reason = srd_pkg::RSN_EG_SRC_NOT_ME;
      end else if (dst_in_pfx) begin
        hop    = dst_emb;
        reason = bad_v4(dst_emb) ? srd_pkg::RSN_EG_BAD_V4_DST : srd_pkg::RSN_OK;
      end else begin
        hop    = cfg_i.relay_v4;
        reason = bad_v6(item_i.inner_v6_dest_high) ? srd_pkg::RSN_EG_BAD_V6_DST
                                                   : srd_pkg::RSN_OK;
      end
    end else begin
      if (len < 12'(srd_pkg::V4HdrBytes)) begin
        reason = srd_pkg::RSN_IN_NO_V4;
      end else if (skip < 6'(srd_pkg::V4HdrBytes)) begin
        reason = srd_pkg::RSN_IN_IHL_SHORT;
      end else if (len < skip_ext) begin
        reason = srd_pkg::RSN_IN_IHL_LONG;
      end else if (len < skip_ext + 12'(srd_pkg::V6HdrBytes)) begin
        reason = srd_pkg::RSN_IN_NO_V6;
      end else if (src_in_pfx && (src_emb != item_i.outer_v4_source)) begin
        reason = srd_pkg::RSN_IN_V4_MISMATCH;
      end else if (src_in_pfx && bad_v4(src_emb)) begin
        reason = srd_pkg::RSN_IN_BAD_V4_SRC;
      end else if (!src_in_pfx && (item_i.outer_v4_source != cfg_i.relay_v4)) begin
        reason = srd_pkg::RSN_IN_NOT_RELAY;
      end else if (!src_in_pfx && bad_v6(item_i.inner_v6_source_high)) begin
        reason = srd_pkg::RSN_IN_BAD_V6_SRC;
      end else if (!dst_in_pfx || (dst_emb != cfg_i.local_v4)) begin
        reason = srd_pkg::RSN_IN_DST_NOT_ME;
      end else begin
        reason = srd_pkg::RSN_OK;
      end
    end
  end

  logic [11:0] eg_len;
  logic [11:0] in_len;

  assign eg_len = len - 12'(srd_pkg::TunHdrBytes);
  assign in_len = len - skip_ext + 12'(srd_pkg::TunHdrBytes);

  // Zero everything but the reason on a drop; ingress never carries a next hop.
  always_comb begin
    res_o.reason      = reason;
    res_o.forward     = (reason == srd_pkg::RSN_OK);
    res_o.next_hop_v4 = 32'd0;
    res_o.out_offset  = 6'd0;
    res_o.out_length  = 11'd0;
    if (reason == srd_pkg::RSN_OK) begin
      if (item_i.opcode == srd_pkg::OP_EGRESS) begin
        res_o.next_hop_v4 = hop;
        res_o.out_offset  = 6'(srd_pkg::TunHdrBytes);
        res_o.out_length  = eg_len[10:0];
      end else begin
        res_o.out_offset  = skip - 6'(srd_pkg::TunHdrBytes);
        res_o.out_length  = in_len[10:0];
      end
    end
  end

endmodule

// File: src/srd_cfg_regs.sv
// Configuration register file with write decode and reset values.
module srd_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  output srd_pkg::cfg_t cfg_o
);

  srd_pkg::cfg_t cfg_q;
  srd_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srd_pkg::CFG_PREFIX_BITS:  cfg_d.prefix_bits     = cfg_wdata_i;
        srd_pkg::CFG_PREFIX_BYTES: cfg_d.prefix_bytes    = cfg_wdata_i[2:0];
        srd_pkg::CFG_MY_V4:        cfg_d.local_v4        = cfg_wdata_i;
        srd_pkg::CFG_RELAY_V4:     cfg_d.relay_v4        = cfg_wdata_i;
        srd_pkg::CFG_FAMILY_IPV6:  cfg_d.tun_family_ipv6 = cfg_wdata_i;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prefix_bits     <= 32'd0;
      cfg_q.prefix_bytes    <= srd_pkg::PrefixBytesReset;
      cfg_q.local_v4        <= 32'd0;
      cfg_q.relay_v4        <= 32'd0;
      cfg_q.tun_family_ipv6 <= srd_pkg::FamilyIpv6Reset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: dv/sixrd_tunnel_header_filter_top_tb.sv
// Testbench for the 6rd tunnel header filter: directed and random headers vs a predictor.
module sixrd_tunnel_header_filter_top_tb;

  localparam int unsigned NumSettings  = 7;
  localparam int unsigned BatchHeaders = 250;
  localparam int unsigned MaxShown     = 10;
  localparam int unsigned DrainCycles  = 10;
  localparam int unsigned TimeoutUnits = 400000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  srd_pkg::in_item_t   in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  srd_pkg::out_item_t  out_data_o;
  logic                cfg_we_i    = 1'b0;
  srd_pkg::cfg_idx_e   cfg_idx_i   = srd_pkg::CFG_PREFIX_BITS;
  logic [31:0]         cfg_wdata_i = '0;

  srd_pkg::cfg_t       cur_cfg = '{prefix_bits: '0, prefix_bytes: srd_pkg::PrefixBytesReset,
                                   local_v4: '0, relay_v4: '0,
                                   tun_family_ipv6: srd_pkg::FamilyIpv6Reset};
  srd_pkg::in_item_t   hdr_queue[$];
  srd_pkg::out_item_t  verdict_queue[$];
  int unsigned n_mismatch    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  sixrd_tunnel_header_filter_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned prefix_len(srd_pkg::cfg_t c);
    if (c.prefix_bytes < 3'd2) return 2;
    if (c.prefix_bytes > 3'd4) return 4;
    return c.prefix_bytes;
  endfunction

  function automatic logic [31:0] prefix_mask(int unsigned pb);
    return 32'hffff_ffff << (32 - 8 * pb);
  endfunction

  function automatic logic has_prefix(logic [63:0] hi, int unsigned pb);
    return (hi[63:32] & prefix_mask(pb)) == (cur_cfg.prefix_bits & prefix_mask(pb));
  endfunction

  function automatic logic [31:0] embedded_v4(logic [63:0] hi, int unsigned pb);
    logic [63:0] sh;
    sh = hi >> (32 - 8 * pb);
    return sh[31:0];
  endfunction

  function automatic logic v4_rejected(logic [31:0] a);
    return a[31:24] == srd_pkg::V4Zero || a[31:24] == srd_pkg::V4Loop ||
           (a & srd_pkg::V4MaskMcast) == srd_pkg::V4Mcast ||
           (a & srd_pkg::V4MaskA) == srd_pkg::V4Net10 ||
           (a & srd_pkg::V4MaskB) == srd_pkg::V4Net172 ||
           (a & srd_pkg::V4MaskC) == srd_pkg::V4Net192 ||
           (a & srd_pkg::V4MaskC) == srd_pkg::V4LinkLocal || a == srd_pkg::V4Bcast;
  endfunction

  function automatic logic v6_rejected(logic [63:0] hi);
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = hi[63:56];
    b1 = hi[55:48];
    return b0 == 8'h00 ||
           (b0 == srd_pkg::V6Mcast &&
            (b1 & srd_pkg::V6ScopeMask) != srd_pkg::V6ScopeGlobal) ||
           (b0 == srd_pkg::V6LinkSite &&
            ((b1 & srd_pkg::V6LlMask) == srd_pkg::V6LinkLocal ||
             (b1 & srd_pkg::V6LlMask) == srd_pkg::V6SiteLocal));
  endfunction

  function automatic srd_pkg::out_item_t judge_header(srd_pkg::in_item_t h);
    srd_pkg::out_item_t r;
    srd_pkg::reason_e   why;
    int unsigned        pb;
    int unsigned        len;
    int unsigned        skip;
    logic [31:0]        hop;
    logic [63:0]        src;
    logic [63:0]        dst;
    r    = '0;
    hop  = '0;
    pb   = prefix_len(cur_cfg);
    len  = h.frame_length;
    skip = 32'(h.ihl_words) * 4;
    src  = h.inner_v6_source_high;
    dst  = h.inner_v6_dest_high;
    if (len >= srd_pkg::MaxFrameBytes) begin
      why = srd_pkg::RSN_TOO_BIG;
    end else if (h.opcode == srd_pkg::OP_EGRESS) begin
      if (len < srd_pkg::TunHdrBytes) why = srd_pkg::RSN_EG_NO_FAMILY;
      else if (h.tun_family_word != cur_cfg.tun_family_ipv6)
        why = srd_pkg::RSN_EG_BAD_FAMILY;
      else if (len - srd_pkg::TunHdrBytes < srd_pkg::V6HdrBytes)
        why = srd_pkg::RSN_EG_NO_V6;
      else if (!has_prefix(src, pb) || embedded_v4(src, pb) != cur_cfg.local_v4)
        why = srd_pkg::RSN_EG_SRC_NOT_ME;
      else if (has_prefix(dst, pb)) begin
        // 6rd peer: the next hop is the address embedded in the destination
        hop = embedded_v4(dst, pb);
        if (v4_rejected(hop)) why = srd_pkg::RSN_EG_BAD_V4_DST;
        else why = srd_pkg::RSN_OK;
      end else begin
        hop = cur_cfg.relay_v4;
        if (v6_rejected(dst)) why = srd_pkg::RSN_EG_BAD_V6_DST;
        else why = srd_pkg::RSN_OK;
      end
      if (why == srd_pkg::RSN_OK) begin
        r.out_offset = 6'(srd_pkg::TunHdrBytes);
        r.out_length = 11'(len - srd_pkg::TunHdrBytes);
      end
    end else begin
      if (len < srd_pkg::V4HdrBytes) why = srd_pkg::RSN_IN_NO_V4;
      else if (skip < srd_pkg::V4HdrBytes) why = srd_pkg::RSN_IN_IHL_SHORT;
      else if (len < skip) why = srd_pkg::RSN_IN_IHL_LONG;
      else if (len - skip < srd_pkg::V6HdrBytes) why = srd_pkg::RSN_IN_NO_V6;
      else if (has_prefix(src, pb) && embedded_v4(src, pb) != h.outer_v4_source)
        why = srd_pkg::RSN_IN_V4_MISMATCH;
      else if (has_prefix(src, pb) && v4_rejected(embedded_v4(src, pb)))
        why = srd_pkg::RSN_IN_BAD_V4_SRC;
      else if (!has_prefix(src, pb) && h.outer_v4_source != cur_cfg.relay_v4)
        why = srd_pkg::RSN_IN_NOT_RELAY;
      else if (!has_prefix(src, pb) && v6_rejected(src))
        why = srd_pkg::RSN_IN_BAD_V6_SRC;
      else if (!has_prefix(dst, pb) || embedded_v4(dst, pb) != cur_cfg.local_v4)
        why = srd_pkg::RSN_IN_DST_NOT_ME;
      else why = srd_pkg::RSN_OK;
      if (why == srd_pkg::RSN_OK) begin
        r.out_offset = 6'(skip - srd_pkg::TunHdrBytes);
        r.out_length = 11'(len - (skip - srd_pkg::TunHdrBytes));
      end
    end
    r.forward     = (why == srd_pkg::RSN_OK);
    r.reason      = why;
    r.next_hop_v4 = (why == srd_pkg::RSN_OK) ? hop : 32'h0;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // A random address or, half the time, one from a reserved IPv4 range.
  function automatic logic [31:0] pick_v4();
    case ($urandom_range(15))
      0:       return {srd_pkg::V4Zero, 24'($urandom)};
      1:       return {srd_pkg::V4Loop, 24'($urandom)};
      2:       return srd_pkg::V4Mcast | ($urandom & ~srd_pkg::V4MaskMcast);
      3:       return srd_pkg::V4Net10 | ($urandom & ~srd_pkg::V4MaskA);
      4:       return srd_pkg::V4Net172 | ($urandom & ~srd_pkg::V4MaskB);
      5:       return srd_pkg::V4Net192 | ($urandom & ~srd_pkg::V4MaskC);
      6:       return srd_pkg::V4LinkLocal | ($urandom & ~srd_pkg::V4MaskC);
      7:       return srd_pkg::V4Bcast;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_v6_hi();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(11))
      0: a[63:56] = 8'h00;
      1: a[63:56] = srd_pkg::V6Mcast;
      2: begin
        a[63:56] = srd_pkg::V6Mcast;
        a[51:48] = srd_pkg::V6ScopeGlobal[3:0];
      end
      3: begin
        a[63:56] = srd_pkg::V6LinkSite;
        a[55:54] = srd_pkg::V6LinkLocal[7:6];
      end
      4: begin
        a[63:56] = srd_pkg::V6LinkSite;
        a[55:54] = srd_pkg::V6SiteLocal[7:6];
      end
      5: a[63:56] = srd_pkg::V6LinkSite;
      default: ;
    endcase
    return a;
  endfunction

  // Upper half of a 6rd address: prefix, then the IPv4 address, then random bits.
  function automatic logic [63:0] sixrd_addr(logic [31:0] v4);
    int unsigned s;
    logic [63:0] low;
    s   = 32 - 8 * prefix_len(cur_cfg);
    low = {$urandom, $urandom};
    return {cur_cfg.prefix_bits & prefix_mask(prefix_len(cur_cfg)), 32'h0} |
           ({32'h0, v4} << s) | (low & ((64'd1 << s) - 64'd1));
  endfunction

  function automatic logic [11:0] pick_len(int unsigned lo);
    case ($urandom_range(19))
      0:       return 12'($urandom_range(lo + 2, 0));
      1:       return 12'($urandom_range(srd_pkg::MaxFrameBytes,
                                         srd_pkg::MaxFrameBytes - 1));
      2:       return 12'($urandom_range(4095, srd_pkg::MaxFrameBytes));
      3:       return 12'(lo);
      default: return 12'($urandom_range(srd_pkg::MaxFrameBytes - 1, lo));
    endcase
  endfunction

  function automatic srd_pkg::in_item_t gen_header();
    srd_pkg::in_item_t h;
    h.opcode               = 1'($urandom);
    h.frame_length         = 12'($urandom);
    h.tun_family_word      = $urandom;
    h.ihl_words            = 4'($urandom);
    h.outer_v4_source      = $urandom;
    h.inner_v6_source_high = {$urandom, $urandom};
    h.inner_v6_dest_high   = {$urandom, $urandom};
    if ($urandom_range(9) == 0) return h;
    if (h.opcode == srd_pkg::OP_EGRESS) begin
      h.frame_length = pick_len(srd_pkg::TunHdrBytes + srd_pkg::V6HdrBytes);
      if ($urandom_range(15) != 0) h.tun_family_word = cur_cfg.tun_family_ipv6;
      h.inner_v6_source_high =
        sixrd_addr(($urandom_range(15) != 0) ? cur_cfg.local_v4 : $urandom);
      if ($urandom_range(15) == 0) h.inner_v6_source_high ^= 64'd1 << $urandom_range(63);
      if ($urandom_range(1) == 0) h.inner_v6_dest_high = sixrd_addr(pick_v4());
      else h.inner_v6_dest_high = pick_v6_hi();
    end else begin
      if ($urandom_range(7) != 0) h.ihl_words = 4'($urandom_range(15, 5));
      h.frame_length = pick_len(32'(h.ihl_words) * 4 + srd_pkg::V6HdrBytes);
      if ($urandom_range(1) == 0) begin
        h.outer_v4_source      = pick_v4();
        h.inner_v6_source_high =
          sixrd_addr(($urandom_range(7) != 0) ? h.outer_v4_source : $urandom);
      end else begin
        h.outer_v4_source      = ($urandom_range(7) != 0) ? cur_cfg.relay_v4 : $urandom;
        h.inner_v6_source_high = pick_v6_hi();
      end
      h.inner_v6_dest_high =
        sixrd_addr(($urandom_range(7) != 0) ? cur_cfg.local_v4 : $urandom);
    end
    return h;
  endfunction

  function automatic srd_pkg::in_item_t mk_hdr(srd_pkg::opcode_e op, int unsigned len,
                                               logic [31:0] fam, logic [3:0] ihl,
                                               logic [31:0] osrc,
                                               logic [63:0] src, logic [63:0] dst);
    srd_pkg::in_item_t h;
    h.opcode               = op;
    h.frame_length         = 12'(len);
    h.tun_family_word      = fam;
    h.ihl_words            = ihl;
    h.outer_v4_source      = osrc;
    h.inner_v6_source_high = src;
    h.inner_v6_dest_high   = dst;
    return h;
  endfunction

  // Register settings: the first one is the base of the directed headers.
  function automatic srd_pkg::cfg_t setting(int unsigned n);
    srd_pkg::cfg_t c;
    c.prefix_bits     = $urandom;
    c.prefix_bytes    = 3'($urandom_range(4, 2));
    c.local_v4        = $urandom;
    c.relay_v4        = $urandom;
    c.tun_family_ipv6 = $urandom;
    case (n)
      0: c = '{prefix_bits: 32'h2001_0db8, prefix_bytes: 3'd4, local_v4: 32'hc633_6401,
               relay_v4: 32'hc058_6301, tun_family_ipv6: srd_pkg::FamilyIpv6Reset};
      1: c.prefix_bytes = 3'd2;
      2: c.prefix_bytes = 3'd3;
      3: c = '{prefix_bits: '1, prefix_bytes: 3'd0, local_v4: '1,
               relay_v4: '1, tun_family_ipv6: '1};
      4: c = '{prefix_bits: '0, prefix_bytes: 3'd7, local_v4: '0,
               relay_v4: '0, tun_family_ipv6: '0};
      5: c.prefix_bytes = 3'd1;
      default: c.prefix_bytes = 3'd5;
    endcase
    return c;
  endfunction

  task automatic write_reg(srd_pkg::cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic load_settings(srd_pkg::cfg_t c);
    write_reg(srd_pkg::CFG_PREFIX_BITS, c.prefix_bits);
    write_reg(srd_pkg::CFG_PREFIX_BYTES, 32'(c.prefix_bytes));
    write_reg(srd_pkg::CFG_MY_V4, c.local_v4);
    write_reg(srd_pkg::CFG_RELAY_V4, c.relay_v4);
    write_reg(srd_pkg::CFG_FAMILY_IPV6, c.tun_family_ipv6);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  // Directed headers against the first setting: 2001:db8::/32, me 198.51.100.1.
  task automatic queue_directed();
    logic [63:0] me6;
    logic [63:0] peer6;
    logic [63:0] native6;
    logic [31:0] fam;
    logic [31:0] relay;
    me6     = 64'h2001_0db8_c633_6401;
    peer6   = 64'h2001_0db8_0808_0808;
    native6 = 64'h2400_cb00_0000_0001;
    fam     = srd_pkg::FamilyIpv6Reset;
    relay   = 32'hc058_6301;
    // egress
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 2048, fam, 4'($urandom), $urandom,
                               me6, peer6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 0, fam, 4'($urandom), $urandom,
                               me6, peer6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 3, fam, 4'($urandom), $urandom,
                               me6, peer6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 100, '1, 4'($urandom), $urandom,
                               me6, peer6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 43, fam, 4'($urandom), $urandom,
                               me6, peer6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 44, fam, 4'($urandom), $urandom,
                               me6, peer6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 80, fam, 4'($urandom), $urandom,
                               64'h2001_0db8_c633_6402, peer6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 80, fam, 4'($urandom), $urandom, me6,
                               64'h2001_0db8_0a01_0203));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 80, fam, 4'($urandom), $urandom, me6,
                               64'hfe80_0000_0000_0000));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 2047, fam, 4'($urandom), $urandom,
                               me6, native6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_EGRESS, 80, fam, 4'($urandom), $urandom, me6,
                               64'hff0e_0000_0000_0001));
    // ingress
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 4095, $urandom, 4'd5, relay,
                               native6, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 19, $urandom, 4'd5, relay,
                               native6, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 100, $urandom, 4'd4, relay,
                               native6, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 59, $urandom, 4'd15, relay,
                               native6, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 99, $urandom, 4'd15, relay,
                               native6, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 100, $urandom, 4'd15, 32'h0808_0808,
                               peer6, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 100, $urandom, 4'd5, 32'h0808_0809,
                               peer6, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 100, $urandom, 4'd5, 32'h7f00_0001,
                               64'h2001_0db8_7f00_0001, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 100, $urandom, 4'd5, 32'h0102_0304,
                               native6, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 100, $urandom, 4'd5, relay,
                               64'hff02_0000_0000_0001, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 100, $urandom, 4'd5, relay,
                               64'hfec0_0000_0000_0001, me6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 100, $urandom, 4'd5, relay,
                               native6, peer6));
    hdr_queue.push_back(mk_hdr(srd_pkg::OP_INGRESS, 2047, $urandom, 4'd5, relay,
                               native6, me6));
  endtask

  // ---------------------------------------------------------------- driver / monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) verdict_queue.push_back(judge_header(in_data_i));
      // hold the header until its transaction completes
      if (!in_valid_i || in_ready_o) begin
        if (hdr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= hdr_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic string verdict_str(srd_pkg::out_item_t v);
    return $sformatf("fwd %0d reason %0d hop %h off %0d len %0d",
                     v.forward, v.reason, v.next_hop_v4, v.out_offset, v.out_length);
  endfunction

  always @(posedge clk_i) begin : monitor
    srd_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_queue.size() == 0) begin
        if (n_mismatch < MaxShown) $display("unexpected verdict: %s", verdict_str(out_data_o));
        n_mismatch++;
      end else begin
        want = verdict_queue.pop_front();
        if (out_data_o.forward !== want.forward || out_data_o.reason !== want.reason ||
            out_data_o.next_hop_v4 !== want.next_hop_v4 ||
            out_data_o.out_offset !== want.out_offset ||
            out_data_o.out_length !== want.out_length) begin
          if (n_mismatch < MaxShown) begin
            $display("verdict mismatch: expected %s", verdict_str(want));
            $display("                  got      %s", verdict_str(out_data_o));
          end
          n_mismatch++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned n = 0; n < NumSettings; n++) begin
      if (n < 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 73;
      end else if (n < 5) begin
        send_idle_pct = 73;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_settings(setting(n));
      if (n == 0) queue_directed();
      for (int unsigned i = 0; i < BatchHeaders; i++) hdr_queue.push_back(gen_header());
      // drain before touching the registers again
      while (hdr_queue.size() != 0 || in_valid_i || verdict_queue.size() != 0)
        @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
    end
    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(TimeoutUnits);
    $display("Test completed with failures");
    $finish;
  end

endmodule
